// File: hw/rtl/union_find_wall_merger_top_defines.svh
// assertion macros used by the checker file
`ifndef UNION_FIND_WALL_MERGER_TOP_DEFINES_SVH
`define UNION_FIND_WALL_MERGER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define UFWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define UFWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ufwm_pkg.sv
package ufwm_pkg;

    // default grid limit
    localparam int MAX_SIDE_DEF = 64;

    // field widths
    localparam int CFG_W      = 7;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int CELL_OUT_W = 12;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index codes, taken from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd16;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd16;

    // input op codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_WALL  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OPENED    = 2'd0,
        ST_CONNECTED = 2'd1,
        ST_INVALID   = 2'd2,
        ST_CLEARED   = 2'd3
    } t_status;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PREP,
        DP_SWEEP,
        DP_RD,
        DP_WALK,
        DP_COMPRESS,
        DP_NEXT,
        DP_LINK,
        DP_OUT_LOAD
    } t_dp_op;

    // datapath status back to the controller
    typedef struct packed {
        logic sweep_last;
        logic is_clear;
        logic wall_ok;
        logic at_root;
        logic start_is_root;
        logic comp_last;
        logic sel;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/ufwm_if.sv
// input item channel
interface ufwm_in_if import ufwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             down;

    modport source (output valid, output op, output row, output col, output down,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input down,
                    output ready);
endinterface

// result item channel
interface ufwm_out_if import ufwm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [CELL_OUT_W-1:0] first_cell;
    logic [CELL_OUT_W-1:0] second_cell;

    modport source (output valid, output status, output first_cell, output second_cell,
                    input ready);
    modport sink   (input valid, input status, input first_cell, input second_cell,
                    output ready);
endinterface

// File: hw/rtl/ufwm_ram.sv
module ufwm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ufwm_ctrl.sv
module ufwm_ctrl import ufwm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_op   o_cmd
);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_PREP,
        S_RD,
        S_WALK,
        S_COMPRESS,
        S_NEXT,
        S_LINK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_report, n_report;

    // next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        o_cmd    = DP_NOP;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd = DP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = r_report ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd = DP_PREP;
                if (i_stat.is_clear) begin
                    n_state  = S_SWEEP;
                    n_report = 1'b1;
                end else if (!i_stat.wall_ok) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd   = DP_RD;
                n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd = DP_WALK;
                if (i_stat.at_root) begin
                    if (i_stat.start_is_root) begin
                        n_state = i_stat.sel ? S_LINK : S_NEXT;
                    end else begin
                        n_state = S_COMPRESS;
                    end
                end
            end
            S_COMPRESS: begin
                o_cmd = DP_COMPRESS;
                if (i_stat.comp_last) begin
                    n_state = i_stat.sel ? S_LINK : S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd   = DP_NEXT;
                n_state = S_RD;
            end
            S_LINK: begin
                o_cmd   = DP_LINK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd    = DP_OUT_LOAD;
                    n_state  = S_IDLE;
                    n_report = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register, reset starts the table clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/ufwm_dp.sv
module ufwm_dp import ufwm_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_dp_op                                 i_cmd,
    output t_dp_stat                               o_stat,
    input  logic [CFG_W-1:0]                       i_grid_width,
    input  logic [CFG_W-1:0]                       i_grid_height,
    input  logic                                   i_op,
    input  logic [ROW_W-1:0]                       i_row,
    input  logic [COL_W-1:0]                       i_col,
    input  logic                                   i_down,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [STATUS_W-1:0]                    o_status,
    output logic [CELL_OUT_W-1:0]                  o_first_cell,
    output logic [CELL_OUT_W-1:0]                  o_second_cell,
    output logic                                   o_mem_we,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   o_mem_waddr,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   o_mem_wdata,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   o_mem_raddr,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   i_mem_rdata
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W = $clog2(DEPTH);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int VW     = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
    localparam int MW     = (CELL_W + CFG_W > CELL_OUT_W) ? CELL_W + CFG_W : CELL_OUT_W;

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(DEPTH - 1);

    // latched input beat
    logic             r_op;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_down;

    // search state
    logic [CELL_W-1:0] r_first, r_second;
    logic [CELL_W-1:0] r_cur, r_root, r_r1;
    logic              r_sel;
    t_status           r_status;
    logic [CELL_W-1:0] r_sweep;

    // output register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [CELL_OUT_W-1:0] r_out_first, r_out_second;

    logic [VW-1:0]     width_ext, height_ext, w_side, h_side;
    logic [VW-1:0]     row_ext, col_ext;
    logic              wall_ok;
    logic [MW-1:0]     first_sum, second_sum;
    logic [MW-1:0]     first_wide, second_wide;
    logic [CELL_W-1:0] start_node;

    // clamp the grid sides to 1..MAX_SIDE
    always_comb begin
        width_ext  = VW'(i_grid_width);
        height_ext = VW'(i_grid_height);
        if (width_ext == '0) begin
            w_side = VW'(1);
        end else if (width_ext > VW'(MAX_SIDE)) begin
            w_side = VW'(MAX_SIDE);
        end else begin
            w_side = width_ext;
        end
        if (height_ext == '0) begin
            h_side = VW'(1);
        end else if (height_ext > VW'(MAX_SIDE)) begin
            h_side = VW'(MAX_SIDE);
        end else begin
            h_side = height_ext;
        end
    end

    // wall check and cell indices
    always_comb begin
        row_ext = VW'(r_row);
        col_ext = VW'(r_col);
        wall_ok = (row_ext < h_side) && (col_ext < w_side);
        if (r_down) begin
            wall_ok = wall_ok && ((row_ext + VW'(1)) < h_side);
        end else begin
            wall_ok = wall_ok && ((col_ext + VW'(1)) < w_side);
        end
        first_sum  = MW'(r_row) * MW'(w_side) + MW'(r_col);
        second_sum = first_sum + (r_down ? MW'(w_side) : MW'(1));
    end

    assign start_node  = r_sel ? r_second : r_first;
    assign first_wide  = MW'(r_first);
    assign second_wide = MW'(r_second);

    // table port drive
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cur;
        o_mem_wdata = r_root;
        o_mem_raddr = r_cur;
        unique case (i_cmd)
            DP_SWEEP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_sweep;
                o_mem_wdata = r_sweep;
            end
            DP_WALK: begin
                o_mem_raddr = (i_mem_rdata != r_cur) ? i_mem_rdata : start_node;
            end
            DP_COMPRESS: begin
                o_mem_we    = 1'b1;
                o_mem_raddr = i_mem_rdata;
            end
            DP_LINK: begin
                o_mem_we    = (r_r1 != r_root);
                o_mem_waddr = r_root;
                o_mem_wdata = r_r1;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.sweep_last    = (r_sweep == LAST_CELL);
        o_stat.is_clear      = (r_op == OP_CLEAR);
        o_stat.wall_ok       = wall_ok;
        o_stat.at_root       = (i_mem_rdata == r_cur);
        o_stat.start_is_root = (start_node == r_cur);
        o_stat.comp_last     = (i_mem_rdata == r_root);
        o_stat.sel           = r_sel;
        o_stat.out_free      = !r_out_valid || i_out_ready;
    end

    // control registers: sweep counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == DP_SWEEP) begin
                r_sweep <= (r_sweep == LAST_CELL) ? '0 : r_sweep + CELL_W'(1);
            end
            if (i_cmd == DP_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and search registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_LOAD: begin
                r_op   <= i_op;
                r_row  <= i_row;
                r_col  <= i_col;
                r_down <= i_down;
            end
            DP_PREP: begin
                r_first  <= first_sum[CELL_W-1:0];
                r_second <= second_sum[CELL_W-1:0];
                r_cur    <= first_sum[CELL_W-1:0];
                r_sel    <= 1'b0;
                if (r_op == OP_CLEAR) begin
                    r_status <= ST_CLEARED;
                end else if (!wall_ok) begin
                    r_status <= ST_INVALID;
                end else begin
                    r_status <= ST_OPENED;
                end
            end
            DP_WALK: begin
                // climb until a node points at itself, then restart for compression
                if (i_mem_rdata != r_cur) begin
                    r_cur <= i_mem_rdata;
                end else begin
                    r_root <= r_cur;
                    r_cur  <= start_node;
                end
            end
            DP_COMPRESS: begin
                r_cur <= i_mem_rdata;
            end
            DP_NEXT: begin
                r_r1  <= r_root;
                r_cur <= r_second;
                r_sel <= 1'b1;
            end
            DP_LINK: begin
                r_status <= (r_r1 != r_root) ? ST_OPENED : ST_CONNECTED;
            end
            DP_OUT_LOAD: begin
                r_out_status <= r_status;
                if (r_status == ST_INVALID || r_status == ST_CLEARED) begin
                    r_out_first  <= '0;
                    r_out_second <= '0;
                end else begin
                    r_out_first  <= first_wide[CELL_OUT_W-1:0];
                    r_out_second <= second_wide[CELL_OUT_W-1:0];
                end
            end
            default: begin
                r_sel <= r_sel;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_cell  = r_out_first;
    assign o_second_cell = r_out_second;

endmodule

// File: hw/rtl/union_find_wall_merger_top.sv
// a wall walks each cell's parent chain to its root and then rewrites the nodes on that
//   chain to point at the root; an invalid wall goes straight to the result
// throughput: one item at a time, set by the single table read port walking parent chains
// a clear beat rewrites the whole table before its result is given
// reset: synchronous active low; afterwards a clearing pass over the whole table
//   holds i_in.ready low, config writes are taken throughout
module union_find_wall_merger_top import ufwm_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ufwm_in_if.sink               i_in,
    ufwm_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W = $clog2(DEPTH);

    logic [CFG_W-1:0] r_grid_width, r_grid_height;

    t_dp_op   cmd;
    t_dp_stat stat;

    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                default:         r_grid_width  <= r_grid_width;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    ufwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ufwm_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_op          (i_in.op),
        .i_row         (i_in.row),
        .i_col         (i_in.col),
        .i_down        (i_in.down),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status      (o_out.status),
        .o_first_cell  (o_out.first_cell),
        .o_second_cell (o_out.second_cell),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    // parent table
    ufwm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// File: hw/rtl/ufwm_chk.sv
`include "union_find_wall_merger_top_defines.svh"

module ufwm_chk import ufwm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [STATUS_W-1:0]   i_out_status,
    input logic [CELL_OUT_W-1:0] i_out_first_cell,
    input logic [CELL_OUT_W-1:0] i_out_second_cell
);

    // a stalled result beat holds
    `UFWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_first_cell) && $stable(i_out_second_cell), "result beat changed while stalled")

    // one item in flight: input closes right after a beat
    `UFWM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input still ready after a beat")

    // cleared and invalid results carry zero cells
    `UFWM_ASSERT_NOW(a_zero_cells, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_INVALID || i_out_status == ST_CLEARED), i_out_first_cell == '0 && i_out_second_cell == '0, "nonzero cells on a cleared or invalid result")

    // a real wall always spans two different cells
    `UFWM_ASSERT_NOW(a_distinct_cells, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_OPENED || i_out_status == ST_CONNECTED), i_out_first_cell != i_out_second_cell, "wall result with equal cells")

endmodule

bind union_find_wall_merger_top ufwm_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_first_cell  (o_out.first_cell),
    .i_out_second_cell (o_out.second_cell)
);

// File: sim/union_find_wall_merger_top_tb.sv
module union_find_wall_merger_top_tb;
    import ufwm_pkg::*;

    localparam int SIDE         = MAX_SIDE_DEF;
    localparam int TABLE_CELLS  = SIDE * SIDE;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int TAIL_CYCLES  = 64;
    localparam int IDLE_PCT     = 14;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 205;
    localparam int N_PHASES     = 8;
    localparam int FIXED_PHASES = 7;
    localparam int QUIET_PHASE  = 4;
    localparam int PRESS_PHASE  = 5;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 23;

    // wall direction and where a directed row takes its expectation from
    localparam logic DIR_RIGHT  = 1'b0;
    localparam logic DIR_DOWN   = 1'b1;
    localparam logic FROM_TABLE = 1'b1;
    localparam logic FROM_MODEL = 1'b0;

    localparam logic [APB_ADDR_W-1:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

    // grid sizes per phase, the last phase picks its own
    localparam int PHASE_COLS [FIXED_PHASES] = '{0, 1, 64, 127, 5, 2, 64};
    localparam int PHASE_ROWS [FIXED_PHASES] = '{0, 64, 1, 127, 7, 2, 64};

    typedef struct packed {
        t_status               status;
        logic [CELL_OUT_W-1:0] first_cell;
        logic [CELL_OUT_W-1:0] second_cell;
    } t_carve_result;

    typedef struct packed {
        logic             op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             down;
        logic             known;
        t_carve_result    want;
    } t_directed_row;

    // directed walls on the reset 16x16 grid
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{OP_WALL,  6'd0,  6'd0,  DIR_RIGHT, FROM_TABLE, '{ST_OPENED,    12'd0,  12'd1}},
        '{OP_WALL,  6'd0,  6'd0,  DIR_DOWN,  FROM_TABLE, '{ST_OPENED,    12'd0,  12'd16}},
        '{OP_WALL,  6'd0,  6'd1,  DIR_DOWN,  FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd1,  6'd0,  DIR_RIGHT, FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd0,  6'd0,  DIR_RIGHT, FROM_TABLE, '{ST_CONNECTED, 12'd0,  12'd1}},
        '{OP_WALL,  6'd0,  6'd15, DIR_RIGHT, FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd15, 6'd0,  DIR_DOWN,  FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd15, 6'd15, DIR_RIGHT, FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd15, 6'd15, DIR_DOWN,  FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd63, 6'd63, DIR_RIGHT, FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd63, 6'd63, DIR_DOWN,  FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd16, 6'd0,  DIR_RIGHT, FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd0,  6'd16, DIR_DOWN,  FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_WALL,  6'd14, 6'd14, DIR_DOWN,  FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd15, 6'd14, DIR_RIGHT, FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd14, 6'd15, DIR_DOWN,  FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd14, 6'd14, DIR_RIGHT, FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_CLEAR, 6'd63, 6'd63, DIR_DOWN,  FROM_TABLE, '{ST_CLEARED,   12'd0,  12'd0}},
        '{OP_WALL,  6'd0,  6'd0,  DIR_RIGHT, FROM_TABLE, '{ST_OPENED,    12'd0,  12'd1}},
        '{OP_WALL,  6'd1,  6'd1,  DIR_RIGHT, FROM_TABLE, '{ST_OPENED,    12'd17, 12'd18}},
        '{OP_WALL,  6'd0,  6'd1,  DIR_DOWN,  FROM_MODEL, '{ST_OPENED,    12'd0,  12'd0}},
        '{OP_WALL,  6'd32, 6'd32, DIR_DOWN,  FROM_TABLE, '{ST_INVALID,   12'd0,  12'd0}},
        '{OP_CLEAR, 6'd0,  6'd0,  DIR_RIGHT, FROM_TABLE, '{ST_CLEARED,   12'd0,  12'd0}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ufwm_in_if  in_ch ();
    ufwm_out_if out_ch ();

    union_find_wall_merger_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: parent links and grid sizes
    logic [CELL_OUT_W-1:0] link_up [TABLE_CELLS];
    logic [CFG_W-1:0]      cols_cfg;
    logic [CFG_W-1:0]      rows_cfg;

    t_carve_result carve_results_q [$];
    int            fail_count  = 0;
    int            cycle_count = 0;
    bit            idle_on     = 1'b1;
    int            hold_cycles = 0;

    function automatic void reset_forest();
        for (int k = 0; k < TABLE_CELLS; k++) link_up[k] = CELL_OUT_W'(k);
    endfunction

    function automatic int unsigned fit_side(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return 32'(v);
    endfunction

    // find the root, then point every node on the path straight at it
    function automatic logic [CELL_OUT_W-1:0] root_of(logic [CELL_OUT_W-1:0] node);
        logic [CELL_OUT_W-1:0] root;
        logic [CELL_OUT_W-1:0] cur;
        logic [CELL_OUT_W-1:0] nxt;
        root = node;
        while (link_up[root] != root) root = link_up[root];
        cur = node;
        while (cur != root) begin
            nxt          = link_up[cur];
            link_up[cur] = root;
            cur          = nxt;
        end
        return root;
    endfunction

    // expected result of one input beat, updating the forest
    function automatic t_carve_result carve_wall(logic op, logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col, logic down);
        t_carve_result         res;
        int unsigned           w;
        int unsigned           h;
        int unsigned           first;
        int unsigned           second;
        logic [CELL_OUT_W-1:0] r1;
        logic [CELL_OUT_W-1:0] r2;
        w               = fit_side(cols_cfg);
        h               = fit_side(rows_cfg);
        res.status      = ST_CLEARED;
        res.first_cell  = '0;
        res.second_cell = '0;
        if (op == OP_CLEAR) begin
            reset_forest();
            return res;
        end
        // edge or outside walls leave the forest alone
        res.status = ST_INVALID;
        if (int'(row) >= h || int'(col) >= w) return res;
        if (down == DIR_DOWN && int'(row) + 1 >= h) return res;
        if (down == DIR_RIGHT && int'(col) + 1 >= w) return res;
        first  = int'(row) * w + int'(col);
        second = (down == DIR_DOWN) ? first + w : first + 1;
        r1 = root_of(CELL_OUT_W'(first));
        r2 = root_of(CELL_OUT_W'(second));
        if (r1 != r2) begin
            link_up[r2] = r1;
            res.status  = ST_OPENED;
        end else begin
            res.status = ST_CONNECTED;
        end
        res.first_cell  = CELL_OUT_W'(first);
        res.second_cell = CELL_OUT_W'(second);
        return res;
    endfunction

    function automatic void report(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // append one expected result beat
    function automatic void queue_expected(t_carve_result res);
        carve_results_q.insert(carve_results_q.size(), res);
    endfunction

    // offer one input beat after a random gap and wait for it to be taken
    task automatic offer_item(input logic op, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic down);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.row   <= row;
        in_ch.col   <= col;
        in_ch.down  <= down;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // apb write: setup cycle, then access until pready, then back to idle
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= (APB_DATA_W'($urandom) << CFG_W) | APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL union_find_wall_merger_top");
        $finish;
    end

    // result side: check each beat, then pick ready for the next cycle
    initial begin : result_sink
        t_carve_result got;
        t_carve_result want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = t_carve_result'({out_ch.status, out_ch.first_cell, out_ch.second_cell});
                if (carve_results_q.size() == 0) begin
                    report($sformatf("unexpected result: status %0d first %0d second %0d",
                                     got.status, got.first_cell, got.second_cell));
                end else begin
                    want = carve_results_q.pop_front();
                    if (got !== want)
                        report($sformatf({"mismatch: status exp %0d got %0d, first exp %0d ",
                                          "got %0d, second exp %0d got %0d"},
                                         want.status, got.status, want.first_cell,
                                         got.first_cell, want.second_cell, got.second_cell));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // input side: reset, directed table, then random phases
    initial begin : item_source
        t_directed_row drow;
        t_carve_result want;
        int unsigned   w;
        int unsigned   h;
        int            pick;
        logic          op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic          down;
        logic [CFG_W-1:0] new_cols;
        logic [CFG_W-1:0] new_rows;

        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_CLEAR;
        in_ch.row   <= '0;
        in_ch.col   <= '0;
        in_ch.down  <= DIR_RIGHT;
        reset_forest();
        cols_cfg = GRID_WIDTH_RST;
        rows_cfg = GRID_HEIGHT_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            drow = DIRECTED[i];
            offer_item(drow.op, drow.row, drow.col, drow.down);
            want = carve_wall(drow.op, drow.row, drow.col, drow.down);
            if (drow.known == FROM_TABLE) want = drow.want;
            queue_expected(want);
        end

        // random phases, sizes written only once the block is drained
        for (int p = 0; p < N_PHASES; p++) begin
            in_ch.valid <= 1'b0;
            while (carve_results_q.size() != 0) @(posedge i_clk);
            if (p < FIXED_PHASES) begin
                new_cols = CFG_W'(PHASE_COLS[p]);
                new_rows = CFG_W'(PHASE_ROWS[p]);
            end else begin
                new_cols = CFG_W'($urandom_range(3, 40));
                new_rows = CFG_W'($urandom_range(3, 40));
            end
            write_reg(ADDR_GRID_WIDTH, new_cols);
            cols_cfg = new_cols;
            write_reg(ADDR_GRID_HEIGHT, new_rows);
            rows_cfg = new_rows;
            idle_on = (p != QUIET_PHASE);
            w = fit_side(cols_cfg);
            h = fit_side(rows_cfg);

            // at random, about half the phases keep the old forest across the size change
            if ($urandom_range(1) == 0) begin
                offer_item(OP_CLEAR, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
                queue_expected(carve_wall(OP_CLEAR, '0, '0, DIR_RIGHT));
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == PRESS_PHASE && n == 20) hold_cycles = HOLD_CYCLES;
                pick = $urandom_range(99);
                row  = ROW_W'($urandom);
                col  = COL_W'($urandom);
                down = 1'($urandom);
                if (pick < 2) begin
                    op = OP_CLEAR;
                end else if (pick < 84) begin
                    // walls owned by cells inside the grid
                    op  = OP_WALL;
                    row = ROW_W'($urandom_range(h - 1));
                    col = COL_W'($urandom_range(w - 1));
                end else begin
                    op = OP_WALL;
                end
                offer_item(op, row, col, down);
                queue_expected(carve_wall(op, row, col, down));
            end
        end

        // drain and let the block settle
        in_ch.valid <= 1'b0;
        while (carve_results_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && carve_results_q.size() == 0)
            $display("PASS union_find_wall_merger_top");
        else
            $display("FAIL union_find_wall_merger_top");
        $finish;
    end

endmodule

// File: union_find_wall_merger_top.f
+incdir+hw/rtl
hw/rtl/ufwm_pkg.sv
hw/rtl/ufwm_if.sv
hw/rtl/ufwm_ram.sv
hw/rtl/ufwm_ctrl.sv
hw/rtl/ufwm_dp.sv
hw/rtl/union_find_wall_merger_top.sv
hw/rtl/ufwm_chk.sv
sim/union_find_wall_merger_top_tb.sv
